/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hdl/swam_pkg.sv */
// Shared constants, operation codes and the count-update command type.
`default_nettype none

package swam_pkg;

	localparam int LETTER_W = 5;
	localparam int LETTER_SLOTS = 32;

	localparam int DEF_ALPHABET_SIZE = 26;
	localparam int DEF_MAX_PATTERN = 32;
	localparam int DEF_POSITION_WIDTH = 16;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_TEXT = 2'd3;

	typedef struct packed {
		logic                valid;
		logic                clear_all;
		logic                empty_win;
		logic                pat_add;
		logic                win_add;
		logic                win_drop;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] old_letter;
	} cnt_cmd_t;

endpackage

`default_nettype wire

/* hdl/swam_ring.sv */
// Ring memory of recent text letters with a registered, write-forwarding read port.
`default_nettype none

module swam_ring
	import swam_pkg::*;
#(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int RAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [RAW-1:0]      wr_addr,
	input  wire logic [LETTER_W-1:0] wr_data,
	input  wire logic [RAW-1:0]      rd_addr,
	output logic      [LETTER_W-1:0] rd_data
);

	logic [LETTER_W-1:0] mem [MAX_PATTERN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/swam_counts.sv */
// Per-letter pattern and window counts with the all-equal detector.
`default_nettype none

module swam_counts
	import swam_pkg::*;
#(
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cnt_cmd_t cmd,
	output logic          no_diff
);

	localparam int CW = $clog2(MAX_PATTERN + 1);

	logic [LETTER_SLOTS-1:0] eq_next;

	for (genvar i = 0; i < LETTER_SLOTS; i++) begin : g_slot
		logic [CW-1:0] win_cnt_q;
		logic [CW-1:0] win_next;
		logic [CW-1:0] pat_next;
		logic          hit_in;
		logic          hit_out;

		assign hit_in = cmd.win_add && (cmd.letter == LETTER_W'(i));
		assign hit_out = cmd.win_drop && (cmd.old_letter == LETTER_W'(i)) && (win_cnt_q != '0);
		assign win_next = (cmd.clear_all || cmd.empty_win) ? '0 :
			win_cnt_q - CW'(hit_out) + CW'(hit_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				win_cnt_q <= '0;
			end else if (cmd.valid) begin
				win_cnt_q <= win_next;
			end
		end

		if (i < ALPHABET_SIZE) begin : g_pat
			logic [CW-1:0] pat_cnt_q;
			logic          pat_in;

			assign pat_in = cmd.pat_add && (cmd.letter == LETTER_W'(i));
			assign pat_next = cmd.clear_all ? '0 : pat_cnt_q + CW'(pat_in);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pat_cnt_q <= '0;
				end else if (cmd.valid) begin
					pat_cnt_q <= pat_next;
				end
			end
		end else begin : g_foreign
			assign pat_next = '0;
		end

		assign eq_next[i] = (pat_next == win_next);
	end

	assign no_diff = &eq_next;

endmodule

`default_nettype wire

/* hdl/sliding_window_anagram_match_core.sv */
// Top level of the sliding-window anagram matcher.
`default_nettype none

// Each input beat carries an operation (clear all, add pattern letter, restart
// text, text letter) and a letter, and produces exactly one result beat with a
// match flag, the matching window's start position and a pattern overflow flag.
// The block takes one beat per clock cycle while the output is not stalled; a
// beat passes an input register and then a result register on its way to the
// output. All letter counts sit in flip-flops cleared by reset, so the block is
// ready right after reset with no clearing pass. The ring of recent letters is
// a memory with a registered read port, its address computed ahead from the
// next pointer and pattern length.
module sliding_window_anagram_match_core
	import swam_pkg::*;
#(
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
	parameter int MAX_PATTERN = DEF_MAX_PATTERN,
	parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [1:0]                operation,
	input  wire logic [LETTER_W-1:0]       letter,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           match,
	output logic      [POSITION_WIDTH-1:0] start_position,
	output logic                           pattern_overflow
);

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int SW = CW + 1;
	localparam int RAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic                      vld_s1;
	logic [1:0]                op_s1;
	logic [LETTER_W-1:0]       letter_s1;

	logic [CW-1:0]             plen_q;
	logic [CW-1:0]             fill_q;
	logic [RAW-1:0]            ptr_q;
	logic [POSITION_WIDTH-1:0] pos_q;

	logic [CW-1:0]             plen_next;
	logic [CW-1:0]             fill_next;
	logic [RAW-1:0]            ptr_next;
	logic [POSITION_WIDTH-1:0] pos_next;

	logic                      out_valid_q;
	logic                      match_q;
	logic [POSITION_WIDTH-1:0] start_q;
	logic                      ovf_q;

	logic                      out_free;
	logic                      advance;
	logic                      accept;
	logic                      is_clear;
	logic                      is_pat;
	logic                      is_restart;
	logic                      is_text;
	logic                      pat_full;
	logic                      pat_take;
	logic                      text_live;
	logic                      win_full;
	logic                      now_full;
	logic                      no_diff;
	logic                      hit;
	logic [RAW-1:0]            ptr_inc;
	logic [SW-1:0]             back_sum;
	logic [RAW-1:0]            rd_addr;
	logic [LETTER_W-1:0]       old_letter;
	logic [POSITION_WIDTH-1:0] start_calc;
	cnt_cmd_t                  cmd;

	assign out_free = !out_valid_q || !out_stall;
	assign advance = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;
	assign accept = in_valid && !in_stall;

	assign is_clear = (op_s1 == OP_CLEAR);
	assign is_pat = (op_s1 == OP_PATTERN);
	assign is_restart = (op_s1 == OP_RESTART);
	assign is_text = (op_s1 == OP_TEXT);

	assign pat_full = (plen_q >= CW'(MAX_PATTERN));
	assign pat_take = is_pat && !pat_full &&
		({1'b0, letter_s1} < (LETTER_W + 1)'(ALPHABET_SIZE));
	assign text_live = is_text && (plen_q != '0);
	assign win_full = (fill_q >= plen_q);
	assign now_full = win_full || ((fill_q + CW'(1)) == plen_q);
	assign hit = text_live && now_full && no_diff;
	assign start_calc = pos_q + POSITION_WIDTH'(1) - POSITION_WIDTH'(plen_q);
	assign ptr_inc = (ptr_q == RAW'(MAX_PATTERN - 1)) ? '0 : ptr_q + RAW'(1);

	always_comb begin
		cmd.valid = advance;
		cmd.clear_all = is_clear;
		cmd.empty_win = is_restart || pat_take;
		cmd.pat_add = pat_take;
		cmd.win_add = text_live;
		cmd.win_drop = text_live && win_full;
		cmd.letter = letter_s1;
		cmd.old_letter = old_letter;
	end

	always_comb begin
		plen_next = plen_q;
		fill_next = fill_q;
		ptr_next = ptr_q;
		pos_next = pos_q;
		if (advance) begin
			case (op_s1)
				OP_CLEAR: begin
					plen_next = '0;
					fill_next = '0;
					ptr_next = '0;
					pos_next = '0;
				end
				OP_PATTERN: begin
					if (pat_take) begin
						plen_next = plen_q + CW'(1);
						fill_next = '0;
						ptr_next = '0;
					end
				end
				OP_RESTART: begin
					fill_next = '0;
					ptr_next = '0;
					pos_next = '0;
				end
				OP_TEXT: begin
					if (text_live) begin
						fill_next = win_full ? fill_q : fill_q + CW'(1);
						ptr_next = ptr_inc;
					end
					pos_next = pos_q + POSITION_WIDTH'(1);
				end
				default: begin
					pos_next = pos_q;
				end
			endcase
		end
	end

	always_comb begin
		back_sum = SW'(ptr_next) + SW'(MAX_PATTERN) - SW'(plen_next);
		if (back_sum >= SW'(MAX_PATTERN)) begin
			rd_addr = RAW'(back_sum - SW'(MAX_PATTERN));
		end else begin
			rd_addr = RAW'(back_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			plen_q <= '0;
			fill_q <= '0;
			ptr_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			plen_q <= plen_next;
			fill_q <= fill_next;
			ptr_q <= ptr_next;
			pos_q <= pos_next;
			if (out_free) begin
				out_valid_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= operation;
			letter_s1 <= letter;
		end
		if (advance) begin
			match_q <= hit;
			start_q <= hit ? start_calc : '0;
			ovf_q <= is_pat && pat_full;
		end
	end

	swam_ring #(
		.MAX_PATTERN(MAX_PATTERN),
		.RAW(RAW)
	) u_ring (
		.clk(clk),
		.wr_en(advance && text_live),
		.wr_addr(ptr_q),
		.wr_data(letter_s1),
		.rd_addr(rd_addr),
		.rd_data(old_letter)
	);

	swam_counts #(
		.ALPHABET_SIZE(ALPHABET_SIZE),
		.MAX_PATTERN(MAX_PATTERN)
	) u_counts (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.no_diff(no_diff)
	);

	assign out_valid = out_valid_q;
	assign match = match_q;
	assign start_position = start_q;
	assign pattern_overflow = ovf_q;

endmodule

`default_nettype wire

/* hdl/swam_checker.sv */
// Port-level checker for the anagram matcher and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module swam_checker
	import swam_pkg::*;
#(
	parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic                      match,
	input wire logic [POSITION_WIDTH-1:0] start_position,
	input wire logic                      pattern_overflow
);

	// A held result beat keeps its contents.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(match) && $stable(start_position) && $stable(pattern_overflow))

	// The input side is only held back when the output side is stalled.
	`ASSERT_SAME(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// A beat cannot both match and report a dropped pattern letter.
	`ASSERT_SAME(a_excl_flags, clk, arst_n, out_valid, !(match && pattern_overflow))

	// The start position is zero unless the beat reports a match.
	`ASSERT_SAME(a_start_zero, clk, arst_n, out_valid && !match, start_position == '0)

endmodule

bind sliding_window_anagram_match_core swam_checker #(
	.POSITION_WIDTH(POSITION_WIDTH)
) u_swam_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.match(match),
	.start_position(start_position),
	.pattern_overflow(pattern_overflow)
);

`default_nettype wire
